FILE: rtl/indexed_insert_erase_list_core_assert.svh
// Assertion macros shared by the list core.
`ifndef INDEXED_INSERT_ERASE_LIST_CORE_ASSERT_SVH
`define INDEXED_INSERT_ERASE_LIST_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IIEL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define IIEL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/iiel_pkg.sv
package iiel_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int IDX_W = 7;
   localparam int VAL_W = 32;
   localparam int GROUP_SIZE = 8;

   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_POP = 3'd1;
   localparam logic [2:0] OP_INSERT = 3'd2;
   localparam logic [2:0] OP_ERASE = 3'd3;
   localparam logic [2:0] OP_ERASE_RANGE = 3'd4;
   localparam logic [2:0] OP_READ = 3'd5;
   localparam logic [2:0] OP_CLEAR = 3'd6;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_BAD = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_READ,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0] op;
      logic [IDX_W-1:0] index;
      logic [IDX_W-1:0] end_index;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic signed [VAL_W-1:0] read_value;
      logic [IDX_W-1:0] count_now;
   } rsp_type;

endpackage

FILE: rtl/iiel_cell.sv
module iiel_cell #(
   parameter int CNT_W = $clog2(iiel_pkg::CAPACITY_DEF + 1),
   parameter int SLOT = 0
) (
   input logic clock,
   input iiel_pkg::cell_cmd_type cmd,
   input logic [CNT_W-1:0] pos,
   input logic signed [iiel_pkg::VAL_W-1:0] val,
   input logic signed [iiel_pkg::VAL_W-1:0] left_data,
   input logic signed [iiel_pkg::VAL_W-1:0] right_data,
   output logic signed [iiel_pkg::VAL_W-1:0] data_out,
   output logic signed [iiel_pkg::VAL_W-1:0] rd_out
);
   import iiel_pkg::*;

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(SLOT);

   logic signed [VAL_W-1:0] data_ff;
   logic signed [VAL_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_INSERT: begin
            // Cells above the insert point take their lower neighbor's word.
            if (pos == MY_POS) begin
               data_in = val;
            end else if (pos < MY_POS) begin
               data_in = left_data;
            end
         end
         CELL_SHIFT: begin
            if (pos <= MY_POS) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign rd_out = (pos == MY_POS) ? data_ff : '0;

endmodule

FILE: rtl/iiel_chain.sv
module iiel_chain #(
   parameter int CAPACITY = iiel_pkg::CAPACITY_DEF,
   parameter int CNT_W = $clog2(iiel_pkg::CAPACITY_DEF + 1)
) (
   input logic clock,
   input iiel_pkg::cell_cmd_type cmd,
   input logic [CNT_W-1:0] pos,
   input logic signed [iiel_pkg::VAL_W-1:0] val,
   output logic signed [iiel_pkg::VAL_W-1:0] rd_data
);
   import iiel_pkg::*;

   localparam int NGRP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   logic signed [VAL_W-1:0] cell_data [CAPACITY];
   logic signed [VAL_W-1:0] cell_rd [CAPACITY];
   logic signed [VAL_W-1:0] grp_ff [NGRP];
   logic signed [VAL_W-1:0] grp_in [NGRP];

   for (genvar s = 0; s < CAPACITY; s++) begin : g_cell
      logic signed [VAL_W-1:0] left_w;
      logic signed [VAL_W-1:0] right_w;

      if (s == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[s-1];
      end

      if (s == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_data[s+1];
      end

      iiel_cell #(
         .CNT_W(CNT_W),
         .SLOT(s)
      ) u_cell (
         .clock(clock),
         .cmd(cmd),
         .pos(pos),
         .val(val),
         .left_data(left_w),
         .right_data(right_w),
         .data_out(cell_data[s]),
         .rd_out(cell_rd[s])
      );
   end

   // Only the addressed cell drives a nonzero word, so an OR tree picks it out.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               grp_in[g] = grp_in[g] | cell_rd[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGRP; g++) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   always_comb begin
      rd_data = '0;
      for (int g = 0; g < NGRP; g++) begin
         rd_data = rd_data | grp_ff[g];
      end
   end

endmodule

FILE: rtl/indexed_insert_erase_list_core.sv
// Ordered list of signed 32-bit words with push, pop, insert, erase, range
// erase, read and clear. Each request on the req_ channel gives exactly one
// response on the rsp_ channel with a status, the word read and the new count.
// Both channels transfer when valid is high and stall is low.
// Push, pop, insert, single erase, clear, a range erase of no or one word and
// any failed request answer from the idle state into the output register.
// A read passes S_READ, where the addressed cell is selected, then S_FINISH,
// which takes the word from the registered OR tree. A longer range erase makes
// its first move on acceptance and the rest in S_SHIFT, since the chain moves
// words one place down per cycle and a gap of N takes N moves; S_FINISH answers.
// A new request is taken when the core is idle and its output register is
// empty or being emptied, so requests answered from idle sustain one per cycle.
// While the receiver stalls, the response is held in the output register and
// the core stops taking requests once that register cannot be freed.
// Reset clears the count and the control state; the stored words are not
// cleared, and only words below the count are ever returned.
`include "indexed_insert_erase_list_core_assert.svh"

module indexed_insert_erase_list_core #(
   parameter int CAPACITY = iiel_pkg::CAPACITY_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input iiel_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output iiel_pkg::rsp_type rsp_data
);
   import iiel_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] gap_ff, gap_in;
   rsp_type pend_ff, pend_in;
   logic is_read_ff, is_read_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   cell_cmd_type cmd;
   logic [CNT_W-1:0] cell_pos;
   logic signed [VAL_W-1:0] rd_data;
   logic rsp_free;
   logic accept;

   iiel_chain #(
      .CAPACITY(CAPACITY),
      .CNT_W(CNT_W)
   ) u_chain (
      .clock(clock),
      .cmd(cmd),
      .pos(cell_pos),
      .val(req_data.value),
      .rd_data(rd_data)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !rsp_free;
   assign accept = req_valid && !req_stall;

   always_comb begin
      logic [CMP_W-1:0] idx_w;
      logic [CMP_W-1:0] end_w;
      logic [CMP_W-1:0] cnt_w;
      logic [CMP_W-1:0] cap_w;
      logic [CMP_W-1:0] gap_w;
      logic [CMP_W-1:0] new_w;
      logic [CNT_W-1:0] idx_pos;
      logic [CNT_W-1:0] new_cnt;
      logic [1:0] status;
      state_type next;
      rsp_type res;

      idx_w = CMP_W'(req_data.index);
      end_w = CMP_W'(req_data.end_index);
      cnt_w = CMP_W'(count_ff);
      cap_w = CMP_W'(CAPACITY);
      gap_w = end_w - idx_w;
      idx_pos = CNT_W'(idx_w);
      new_cnt = count_ff;
      new_w = '0;
      status = ST_OK;
      next = S_IDLE;
      res = '0;

      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      gap_in = gap_ff;
      pend_in = pend_ff;
      is_read_in = is_read_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      cmd = CELL_HOLD;
      cell_pos = pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               is_read_in = 1'b0;
               unique case (req_data.op)
                  OP_PUSH: begin
                     if (cnt_w >= cap_w) begin
                        status = ST_FULL;
                     end else begin
                        cmd = CELL_INSERT;
                        cell_pos = count_ff;
                        new_cnt = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status = ST_BAD;
                     end else begin
                        new_cnt = count_ff - 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     // A bad index wins over a full list.
                     if (idx_w > cnt_w) begin
                        status = ST_BAD;
                     end else if (cnt_w >= cap_w) begin
                        status = ST_FULL;
                     end else begin
                        cmd = CELL_INSERT;
                        cell_pos = idx_pos;
                        new_cnt = count_ff + 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     if (idx_w >= cnt_w) begin
                        status = ST_BAD;
                     end else begin
                        cmd = CELL_SHIFT;
                        cell_pos = idx_pos;
                        new_cnt = count_ff - 1'b1;
                     end
                  end
                  OP_ERASE_RANGE: begin
                     if ((idx_w > end_w) || (end_w > cnt_w)) begin
                        status = ST_BAD;
                     end else if (end_w > idx_w) begin
                        // The first move happens now; the rest follow in S_SHIFT.
                        cmd = CELL_SHIFT;
                        cell_pos = idx_pos;
                        new_cnt = count_ff - CNT_W'(gap_w);
                        pos_in = idx_pos;
                        gap_in = CNT_W'(gap_w) - 1'b1;
                        if (gap_w != CMP_W'(1)) begin
                           next = S_SHIFT;
                        end
                     end
                  end
                  OP_READ: begin
                     if (idx_w >= cnt_w) begin
                        status = ST_BAD;
                     end else begin
                        pos_in = idx_pos;
                        is_read_in = 1'b1;
                        next = S_READ;
                     end
                  end
                  OP_CLEAR: begin
                     new_cnt = '0;
                  end
                  default: begin
                     status = ST_BAD;
                  end
               endcase

               new_w = CMP_W'(new_cnt);
               res.status = status;
               res.read_value = '0;
               res.count_now = new_w[IDX_W-1:0];
               count_in = new_cnt;
               if (next == S_IDLE) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = res;
               end else begin
                  pend_in = res;
                  state_in = next;
               end
            end
         end
         S_SHIFT: begin
            cmd = CELL_SHIFT;
            gap_in = gap_ff - 1'b1;
            if (gap_ff == CNT_W'(1)) begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = pend_ff;
               rsp_data_in.read_value = is_read_ff ? rd_data : '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      gap_ff <= gap_in;
      pend_ff <= pend_in;
      is_read_ff <= is_read_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `IIEL_ASSERT_NOW(a_count_range, clock, reset, 1'b1, CMP_W'(count_ff) <= CMP_W'(CAPACITY), "count exceeds capacity")
   `IIEL_ASSERT_NEXT(a_shift_ends, clock, reset, (state_ff == S_SHIFT) && (gap_ff == CNT_W'(1)), state_ff == S_FINISH, "range erase did not finish")
   `IIEL_ASSERT_NEXT(a_read_path, clock, reset, state_ff == S_READ, (state_ff == S_FINISH) && is_read_ff, "read lost its way to finish")
   `IIEL_ASSERT_NEXT(a_finish_out, clock, reset, (state_ff == S_FINISH) && !rsp_stall, rsp_valid_ff && (state_ff == S_IDLE), "finished request gave no response")

endmodule

FILE: dv/tb_indexed_insert_erase_list_core.sv
`timescale 1ns / 100ps

module tb_indexed_insert_erase_list_core;
   import iiel_pkg::*;

   localparam int CAP = CAPACITY_DEF;
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 100;
   localparam int MIXED_ITEMS = 100;

   typedef enum {MIX_RANDOM, MIX_FILL, MIX_DRAIN} traffic_mix_type;

   typedef struct {
      req_type req;
      bit has_golden;
      rsp_type golden;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the list, advanced once per accepted request.
   logic signed [VAL_W-1:0] mirror_words [CAP];
   int unsigned mirror_count = 0;

   rsp_type pending_rsp_q [$];
   stim_row_type directed_rows [$];
   int mismatch_count = 0;
   int rsp_seen = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int long_holds_asked = 0;

   indexed_insert_erase_list_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("indexed_insert_erase_list_core regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) begin
         $display("[%0t] response %0d: %s", $realtime, rsp_seen, what);
      end
      mismatch_count++;
   endtask

   function automatic void shift_words_down(input int unsigned from, input int unsigned gap);
      for (int unsigned i = from; i < mirror_count; i++) begin
         mirror_words[i - gap] = mirror_words[i];
      end
      mirror_count -= gap;
   endfunction

   function automatic rsp_type predict_list_result(input req_type r);
      rsp_type res;
      int unsigned idx;
      int unsigned lim;
      idx = r.index;
      lim = r.end_index;
      res = '0;
      res.status = ST_OK;
      case (r.op)
         OP_PUSH: begin
            if (mirror_count >= CAP) begin
               res.status = ST_FULL;
            end else begin
               mirror_words[mirror_count] = r.value;
               mirror_count++;
            end
         end
         OP_POP: begin
            if (mirror_count == 0) res.status = ST_BAD;
            else mirror_count--;
         end
         OP_INSERT: begin
            // A bad index wins over a full list.
            if (idx > mirror_count) begin
               res.status = ST_BAD;
            end else if (mirror_count >= CAP) begin
               res.status = ST_FULL;
            end else begin
               for (int unsigned i = mirror_count; i > idx; i--) begin
                  mirror_words[i] = mirror_words[i - 1];
               end
               mirror_words[idx] = r.value;
               mirror_count++;
            end
         end
         OP_ERASE: begin
            if (idx >= mirror_count) res.status = ST_BAD;
            else shift_words_down(idx + 1, 1);
         end
         OP_ERASE_RANGE: begin
            if (idx > lim || lim > mirror_count) res.status = ST_BAD;
            else if (lim > idx) shift_words_down(lim, lim - idx);
         end
         OP_READ: begin
            if (idx >= mirror_count) res.status = ST_BAD;
            else res.read_value = mirror_words[idx];
         end
         OP_CLEAR: begin
            mirror_count = 0;
         end
         default: begin
            res.status = ST_BAD;
         end
      endcase
      res.count_now = IDX_W'(mirror_count);
      return res;
   endfunction

   function automatic stim_row_type stim_row(input logic [2:0] op, input int idx, input int lim,
                                             input logic [31:0] value, input bit has_golden,
                                             input logic [1:0] st, input logic [31:0] rd,
                                             input int cnt);
      stim_row_type row;
      row.req.op = op;
      row.req.index = IDX_W'(idx);
      row.req.end_index = IDX_W'(lim);
      row.req.value = value;
      row.has_golden = has_golden;
      row.golden.status = st;
      row.golden.read_value = rd;
      row.golden.count_now = IDX_W'(cnt);
      return row;
   endfunction

   // Random request shaped by the current list length, so that most requests
   // land on valid positions and a few are deliberately out of range.
   function automatic req_type random_list_req(input traffic_mix_type mix);
      req_type r;
      int unsigned n;
      int unsigned pick;
      int unsigned start;
      int unsigned room;
      bit noise;
      n = mirror_count;
      pick = $urandom_range(99);
      noise = ($urandom_range(15) == 0);
      r.index = IDX_W'($urandom_range(127));
      r.end_index = IDX_W'($urandom_range(127));
      case ($urandom_range(7))
         0: r.value = 32'sh7FFFFFFF;
         1: r.value = 32'sh80000000;
         2: r.value = '0;
         3: r.value = -32'sd1;
         default: r.value = $urandom();
      endcase
      if (pick < 10) r.op = OP_READ;
      else if (mix == MIX_FILL) r.op = (pick < 55) ? OP_PUSH : OP_INSERT;
      else if (mix == MIX_DRAIN) r.op = (pick < 40) ? OP_POP : (pick < 60) ? OP_ERASE : OP_ERASE_RANGE;
      else if (pick < 12) r.op = (pick == 10) ? OP_CLEAR : OP_UNUSED;
      else if (pick < 56) r.op = (pick < 34) ? OP_PUSH : OP_INSERT;
      else if (pick < 70) r.op = OP_POP;
      else if (pick < 85) r.op = OP_ERASE;
      else r.op = OP_ERASE_RANGE;
      if (!noise) begin
         case (r.op)
            OP_INSERT: r.index = IDX_W'($urandom_range(n));
            OP_READ, OP_ERASE: r.index = IDX_W'((n == 0) ? 0 : $urandom_range(n - 1));
            OP_ERASE_RANGE: begin
               start = $urandom_range(n);
               room = n - start;
               // Wide ranges are slow, so outside draining most stay short.
               if (mix != MIX_DRAIN && $urandom_range(9) != 0 && room > 3) room = 3;
               r.index = IDX_W'(start);
               r.end_index = IDX_W'(start + $urandom_range(room));
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic send_req(input req_type r, input bit has_golden, input rsp_type golden);
      bit taken;
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      taken = 1'b0;
      // Stall is settled mid-cycle, so it tells whether the next edge transfers.
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      predicted = predict_list_result(r);
      pending_rsp_q.push_back(has_golden ? golden : predicted);
   endtask

   task automatic send_mixed(input traffic_mix_type mix);
      send_req(random_list_req(mix), 1'b0, '0);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      req_type r;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      // The long hold only comes in phases where the receiver may idle.
      if (stall_pct > 0) long_holds_asked++;
      while (mirror_count < CAP) send_mixed(MIX_FILL);
      repeat (2) send_mixed(MIX_FILL);
      r = random_list_req(MIX_FILL);
      r.op = OP_PUSH;
      send_req(r, 1'b0, '0);
      r.op = OP_INSERT;
      r.index = IDX_W'($urandom_range(CAP));
      send_req(r, 1'b0, '0);
      r.index = IDX_W'($urandom_range(127, CAP + 1));
      send_req(r, 1'b0, '0);
      repeat (MIXED_ITEMS) send_mixed(MIX_RANDOM);
      while (mirror_count > 0) send_mixed(MIX_DRAIN);
      repeat (3) send_mixed(MIX_DRAIN);
      repeat (MIXED_ITEMS) send_mixed(MIX_RANDOM);
   endtask

   initial begin : rsp_side
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (holds_served != long_holds_asked) begin
            holds_served = long_holds_asked;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   always @(negedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               report_mismatch($sformatf("status %0d, wanted %0d", rsp_data.status, want.status));
            end
            if (rsp_data.read_value !== want.read_value) begin
               report_mismatch($sformatf("read_value %0d, wanted %0d",
                                         rsp_data.read_value, want.read_value));
            end
            if (rsp_data.count_now !== want.count_now) begin
               report_mismatch($sformatf("count_now %0d, wanted %0d",
                                         rsp_data.count_now, want.count_now));
            end
         end
      end
   end

   initial begin : stimulus
      // Empty list first: every failing case, then known words at both extremes.
      directed_rows.push_back(stim_row(OP_POP, 0, 0, 0, 1, ST_BAD, 0, 0));
      directed_rows.push_back(stim_row(OP_READ, 0, 0, 0, 1, ST_BAD, 0, 0));
      directed_rows.push_back(stim_row(OP_ERASE, 0, 0, 0, 1, ST_BAD, 0, 0));
      directed_rows.push_back(stim_row(OP_INSERT, 1, 0, 5, 1, ST_BAD, 0, 0));
      directed_rows.push_back(stim_row(OP_ERASE_RANGE, 0, 0, 0, 1, ST_OK, 0, 0));
      directed_rows.push_back(stim_row(OP_ERASE_RANGE, 0, 1, 0, 1, ST_BAD, 0, 0));
      directed_rows.push_back(stim_row(OP_CLEAR, 0, 0, 0, 1, ST_OK, 0, 0));
      directed_rows.push_back(stim_row(OP_UNUSED, 127, 127, 32'hFFFFFFFF, 1, ST_BAD, 0, 0));
      directed_rows.push_back(stim_row(OP_PUSH, 0, 0, 32'h7FFFFFFF, 1, ST_OK, 0, 1));
      directed_rows.push_back(stim_row(OP_PUSH, 127, 127, 32'h80000000, 1, ST_OK, 0, 2));
      directed_rows.push_back(stim_row(OP_READ, 0, 0, 0, 1, ST_OK, 32'h7FFFFFFF, 2));
      directed_rows.push_back(stim_row(OP_READ, 1, 0, 0, 1, ST_OK, 32'h80000000, 2));
      directed_rows.push_back(stim_row(OP_READ, 2, 0, 0, 1, ST_BAD, 0, 2));
      directed_rows.push_back(stim_row(OP_INSERT, 2, 0, 32'h12345678, 1, ST_OK, 0, 3));
      directed_rows.push_back(stim_row(OP_INSERT, 0, 0, 32'hFFFFFFFF, 1, ST_OK, 0, 4));
      directed_rows.push_back(stim_row(OP_READ, 1, 0, 0, 1, ST_OK, 32'h7FFFFFFF, 4));
      directed_rows.push_back(stim_row(OP_ERASE_RANGE, 3, 1, 0, 1, ST_BAD, 0, 4));
      directed_rows.push_back(stim_row(OP_INSERT, 127, 0, 7, 1, ST_BAD, 0, 4));
      directed_rows.push_back(stim_row(OP_ERASE, 127, 0, 0, 1, ST_BAD, 0, 4));
      directed_rows.push_back(stim_row(OP_ERASE, 0, 0, 0, 1, ST_OK, 0, 3));
      directed_rows.push_back(stim_row(OP_READ, 0, 0, 0, 0, ST_OK, 0, 0));
      directed_rows.push_back(stim_row(OP_ERASE_RANGE, 1, 3, 0, 0, ST_OK, 0, 0));
      directed_rows.push_back(stim_row(OP_READ, 0, 0, 0, 0, ST_OK, 0, 0));
      directed_rows.push_back(stim_row(OP_CLEAR, 0, 0, 0, 1, ST_OK, 0, 0));
      directed_rows.push_back(stim_row(OP_READ, 0, 0, 0, 1, ST_BAD, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].req, directed_rows[i].has_golden, directed_rows[i].golden);
      end

      run_phase(9, 65);
      run_phase(65, 9);
      run_phase(0, 0);

      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("indexed_insert_erase_list_core regression: pass");
      end else begin
         $display("indexed_insert_erase_list_core regression: fail");
      end
      $finish;
   end

endmodule
